FILE: rtl/cama_pkg.sv
`default_nettype none

package cama_pkg;

    // Field widths of the pixel stream and the register file.
    localparam int ALPHA_W     = 8;
    localparam int COORD_W     = 14;
    localparam int DIM_FIELD_W = 13;
    localparam int CFG_DATA_W  = 26;
    localparam int CFG_IDX_W   = 3;
    localparam int CLEAR_W     = 9;

    // Signed width that holds every intermediate edge of the clipping math.
    localparam int CLIP_W = 17;

    // Hold-off after a register write while the clip pipeline refills.
    localparam int SETTLE_W = 3;
    localparam logic [SETTLE_W-1:0] SETTLE_CYCLES = 3'd4;

    // Reset value of the clear register (-1 keeps outside pixels).
    localparam logic signed [CLEAR_W-1:0] CLEAR_RESET = '1;

    // Register indexes on the configuration port.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DST_X       = 3'd0,
        REG_DST_Y       = 3'd1,
        REG_SRC_X       = 3'd2,
        REG_SRC_Y       = 3'd3,
        REG_RECT_SIZE   = 3'd4,
        REG_SRC_DIMS    = 3'd5,
        REG_DST_DIMS    = 3'd6,
        REG_CLEAR_VALUE = 3'd7
    } cfg_index_t;

    // Contents of the register file.
    typedef struct packed {
        logic signed [COORD_W-1:0] dst_x;
        logic signed [COORD_W-1:0] dst_y;
        logic signed [COORD_W-1:0] src_x;
        logic signed [COORD_W-1:0] src_y;
        logic [CFG_DATA_W-1:0]     rect_size;
        logic [CFG_DATA_W-1:0]     src_dims;
        logic [CFG_DATA_W-1:0]     dst_dims;
        logic signed [CLEAR_W-1:0] clear_value;
    } cfg_t;

    // Clipped rectangle in destination coordinates, half-open bounds.
    typedef struct packed {
        logic signed [CLIP_W-1:0] x_lo;
        logic signed [CLIP_W-1:0] x_hi;
        logic signed [CLIP_W-1:0] y_lo;
        logic signed [CLIP_W-1:0] y_hi;
        logic                     active;
        logic                     hit_ok;
    } clip_rect_t;

endpackage

`default_nettype wire

FILE: rtl/cama_clip.sv
`default_nettype none

module cama_clip #(
    parameter int MAX_DIM = 4096,
    localparam int DW = $clog2(MAX_DIM + 1),
    localparam int CW = $clog2(MAX_DIM)
) (
    input  wire logic                  aclk,
    input  wire cama_pkg::cfg_t        cfg,
    output cama_pkg::clip_rect_t       rect,
    output logic [CW-1:0]              col_last,
    output logic [CW-1:0]              row_last
);
    import cama_pkg::*;

    // Image dimensions above MAX_DIM are taken as MAX_DIM.
    function automatic logic [DW-1:0] clamp_dim(input logic [DIM_FIELD_W-1:0] f);
        logic [DW-1:0] res;
        if (32'(f) > 32'(MAX_DIM)) begin
            res = DW'(MAX_DIM);
        end else begin
            res = DW'(f);
        end
        return res;
    endfunction

    // The last raster index; a zero dimension counts as one pixel.
    function automatic logic [CW-1:0] last_index(input logic [DW-1:0] d);
        logic [CW-1:0] res;
        if (d == '0) begin
            res = '0;
        end else begin
            res = CW'(d - DW'(1));
        end
        return res;
    endfunction

    logic signed [CLIP_W-1:0] dx, dy, sx, sy, w, h;
    logic [DW-1:0]            siw, sih, diw, dih;

    logic signed [CLIP_W-1:0] s1_dx_reg, s1_dy_reg, s1_dsx_reg, s1_dsy_reg;
    logic signed [CLIP_W-1:0] s1_dxw_reg, s1_dyh_reg;
    logic signed [CLIP_W-1:0] s1_siw_reg, s1_sih_reg, s1_diw_reg, s1_dih_reg;
    logic                     s1_active_reg;
    logic [CW-1:0]            col_last_reg, row_last_reg;

    logic signed [CLIP_W-1:0] s2_lo_x_next, s2_hi_x_next, s2_lo_y_next, s2_hi_y_next;
    logic signed [CLIP_W-1:0] s2_lo_x_reg, s2_hi_x_reg, s2_lo_y_reg, s2_hi_y_reg;
    logic signed [CLIP_W-1:0] s2_diw_reg, s2_dih_reg;
    logic                     s2_active_reg;

    logic signed [CLIP_W-1:0] s3_lo_x_next, s3_hi_x_next, s3_lo_y_next, s3_hi_y_next;
    logic signed [CLIP_W-1:0] s3_lo_x_reg, s3_hi_x_reg, s3_lo_y_reg, s3_hi_y_reg;
    logic                     s3_active_reg;

    clip_rect_t               rect_next, rect_reg;

    // Stage one: widen the fields and clamp the image sizes.
    always_comb begin
        dx  = CLIP_W'(cfg.dst_x);
        dy  = CLIP_W'(cfg.dst_y);
        sx  = CLIP_W'(cfg.src_x);
        sy  = CLIP_W'(cfg.src_y);
        w   = signed'(CLIP_W'(cfg.rect_size[DIM_FIELD_W-1:0]));
        h   = signed'(CLIP_W'(cfg.rect_size[2*DIM_FIELD_W-1:DIM_FIELD_W]));
        siw = clamp_dim(cfg.src_dims[DIM_FIELD_W-1:0]);
        sih = clamp_dim(cfg.src_dims[2*DIM_FIELD_W-1:DIM_FIELD_W]);
        diw = clamp_dim(cfg.dst_dims[DIM_FIELD_W-1:0]);
        dih = clamp_dim(cfg.dst_dims[2*DIM_FIELD_W-1:DIM_FIELD_W]);
    end

    always_ff @(posedge aclk) begin
        s1_dx_reg     <= dx;
        s1_dy_reg     <= dy;
        s1_dsx_reg    <= dx - sx;
        s1_dsy_reg    <= dy - sy;
        s1_dxw_reg    <= dx + w;
        s1_dyh_reg    <= dy + h;
        s1_siw_reg    <= signed'(CLIP_W'(siw));
        s1_sih_reg    <= signed'(CLIP_W'(sih));
        s1_diw_reg    <= signed'(CLIP_W'(diw));
        s1_dih_reg    <= signed'(CLIP_W'(dih));
        s1_active_reg <= (w != '0) && (h != '0);
        col_last_reg  <= last_index(diw);
        row_last_reg  <= last_index(dih);
    end

    // Stage two: the rectangle's span limited by the source image, in
    // destination coordinates.
    always_comb begin
        s2_lo_x_next = (s1_dsx_reg > s1_dx_reg) ? s1_dsx_reg : s1_dx_reg;
        s2_lo_y_next = (s1_dsy_reg > s1_dy_reg) ? s1_dsy_reg : s1_dy_reg;
        s2_hi_x_next = (s1_dsx_reg + s1_siw_reg < s1_dxw_reg) ?
                       s1_dsx_reg + s1_siw_reg : s1_dxw_reg;
        s2_hi_y_next = (s1_dsy_reg + s1_sih_reg < s1_dyh_reg) ?
                       s1_dsy_reg + s1_sih_reg : s1_dyh_reg;
    end

    always_ff @(posedge aclk) begin
        s2_lo_x_reg   <= s2_lo_x_next;
        s2_hi_x_reg   <= s2_hi_x_next;
        s2_lo_y_reg   <= s2_lo_y_next;
        s2_hi_y_reg   <= s2_hi_y_next;
        s2_diw_reg    <= s1_diw_reg;
        s2_dih_reg    <= s1_dih_reg;
        s2_active_reg <= s1_active_reg;
    end

    // Stage three: limit the span by the destination image.
    always_comb begin
        s3_lo_x_next = s2_lo_x_reg[CLIP_W-1] ? '0 : s2_lo_x_reg;
        s3_lo_y_next = s2_lo_y_reg[CLIP_W-1] ? '0 : s2_lo_y_reg;
        s3_hi_x_next = (s2_diw_reg < s2_hi_x_reg) ? s2_diw_reg : s2_hi_x_reg;
        s3_hi_y_next = (s2_dih_reg < s2_hi_y_reg) ? s2_dih_reg : s2_hi_y_reg;
    end

    always_ff @(posedge aclk) begin
        s3_lo_x_reg   <= s3_lo_x_next;
        s3_hi_x_reg   <= s3_hi_x_next;
        s3_lo_y_reg   <= s3_lo_y_next;
        s3_hi_y_reg   <= s3_hi_y_next;
        s3_active_reg <= s2_active_reg;
    end

    // Stage four: an empty span in either axis leaves no pixel inside.
    always_comb begin
        rect_next.x_lo   = s3_lo_x_reg;
        rect_next.x_hi   = s3_hi_x_reg;
        rect_next.y_lo   = s3_lo_y_reg;
        rect_next.y_hi   = s3_hi_y_reg;
        rect_next.active = s3_active_reg;
        rect_next.hit_ok = s3_active_reg && (s3_hi_x_reg > s3_lo_x_reg) &&
                           (s3_hi_y_reg > s3_lo_y_reg);
    end

    always_ff @(posedge aclk) begin
        rect_reg <= rect_next;
    end

    assign rect     = rect_reg;
    assign col_last = col_last_reg;
    assign row_last = row_last_reg;

endmodule

`default_nettype wire

FILE: rtl/clipped_alpha_mask_multiply_core.sv
`default_nettype none

// Clipped alpha mask multiply. Destination pixels stream in raster order, one
// transaction per pixel, with the source alpha already fetched for the mapped
// position; the block tracks the raster position itself and flags the last
// pixel of each destination frame. Pixels inside the clipped rectangle get
// dst*src/255 (rounded as (n + (n >> 7)) >> 8); pixels outside get the clear
// value, or pass unchanged when it is negative; a zero rectangle width or
// height passes everything. The block accepts one pixel per cycle whenever
// s_ready is high (not during the hold-off, nor while the results stall), and
// delivers each result through an input register and a result register. The
// clipped rectangle is computed from the registers by a four-stage pipeline,
// so after reset and every register write the input waits until it settles.
module clipped_alpha_mask_multiply_core #(
    parameter int MAX_DIM = 4096
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,

    input  wire logic                                cfg_wr_en,
    input  wire logic [cama_pkg::CFG_IDX_W-1:0]      cfg_wr_index,
    input  wire logic [cama_pkg::CFG_DATA_W-1:0]     cfg_wr_data,

    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic [cama_pkg::ALPHA_W-1:0]        s_dst_alpha,
    input  wire logic [cama_pkg::ALPHA_W-1:0]        s_src_alpha,

    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic [cama_pkg::ALPHA_W-1:0]             m_alpha_out,
    output logic                                     m_inside_res,
    output logic                                     m_frame_end
);
    import cama_pkg::*;

    localparam int CW = $clog2(MAX_DIM);

    // Register file after reset: everything zero except the clear value.
    localparam cfg_t CFG_RESET = cfg_t'({($bits(cfg_t) - CLEAR_W)'(0), CLEAR_RESET});

    cfg_t                     cfg_reg, cfg_next;
    logic [SETTLE_W-1:0]      settle_cnt_reg, settle_cnt_next;

    clip_rect_t               rect;
    logic [CW-1:0]            col_last, row_last;

    logic [CW-1:0]            col_reg, col_next, row_reg, row_next;
    logic                     col_wrap, row_wrap;

    logic                     accept, advance;
    logic                     in_valid_reg, in_valid_next;
    logic [ALPHA_W-1:0]       in_dst_reg, in_src_reg;
    logic [CW-1:0]            in_col_reg, in_row_reg;
    logic                     in_last_reg;

    logic [2*ALPHA_W-1:0]     product;
    logic [2*ALPHA_W:0]       scaled_sum;
    logic signed [CLIP_W-1:0] pix_x, pix_y;
    logic                     pix_in_rect;
    logic [ALPHA_W-1:0]       alpha_result;

    logic                     out_valid_reg, out_valid_next;
    logic [ALPHA_W-1:0]       out_alpha_reg;
    logic                     out_inside_reg, out_last_reg;

    // Register file writes.
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index_t'(cfg_wr_index))
                REG_DST_X:       cfg_next.dst_x       = cfg_wr_data[COORD_W-1:0];
                REG_DST_Y:       cfg_next.dst_y       = cfg_wr_data[COORD_W-1:0];
                REG_SRC_X:       cfg_next.src_x       = cfg_wr_data[COORD_W-1:0];
                REG_SRC_Y:       cfg_next.src_y       = cfg_wr_data[COORD_W-1:0];
                REG_RECT_SIZE:   cfg_next.rect_size   = cfg_wr_data;
                REG_SRC_DIMS:    cfg_next.src_dims    = cfg_wr_data;
                REG_DST_DIMS:    cfg_next.dst_dims    = cfg_wr_data;
                REG_CLEAR_VALUE: cfg_next.clear_value = cfg_wr_data[CLEAR_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    // Hold off new pixels until the clip pipeline reflects the registers.
    always_comb begin
        if (cfg_wr_en) begin
            settle_cnt_next = SETTLE_CYCLES;
        end else if (settle_cnt_reg != '0) begin
            settle_cnt_next = settle_cnt_reg - SETTLE_W'(1);
        end else begin
            settle_cnt_next = settle_cnt_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg        <= CFG_RESET;
            settle_cnt_reg <= SETTLE_CYCLES;
        end else begin
            cfg_reg        <= cfg_next;
            settle_cnt_reg <= settle_cnt_next;
        end
    end

    cama_clip #(
        .MAX_DIM (MAX_DIM)
    ) u_clip (
        .aclk     (aclk),
        .cfg      (cfg_reg),
        .rect     (rect),
        .col_last (col_last),
        .row_last (row_last)
    );

    // Handshake: the input register moves on whenever the result register
    // is empty or being drained.
    assign advance = !out_valid_reg || m_ready;
    assign s_ready = (settle_cnt_reg == '0) && (!in_valid_reg || advance);
    assign accept  = s_valid && s_ready;

    // Raster position; an index at or past the last one wraps.
    always_comb begin
        col_wrap = (col_reg >= col_last);
        row_wrap = (row_reg >= row_last);
        col_next = col_reg;
        row_next = row_reg;
        if (accept) begin
            if (col_wrap) begin
                col_next = '0;
                if (row_wrap) begin
                    row_next = '0;
                end else begin
                    row_next = row_reg + CW'(1);
                end
            end else begin
                col_next = col_reg + CW'(1);
            end
        end
    end

    always_comb begin
        if (accept) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end else begin
            in_valid_next = in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg      <= '0;
            row_reg      <= '0;
            in_valid_reg <= 1'b0;
        end else begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            in_valid_reg <= in_valid_next;
        end
    end

    // Input register: the pixel together with its raster position.
    always_ff @(posedge aclk) begin
        if (accept) begin
            in_dst_reg  <= s_dst_alpha;
            in_src_reg  <= s_src_alpha;
            in_col_reg  <= col_reg;
            in_row_reg  <= row_reg;
            in_last_reg <= col_wrap && row_wrap;
        end
    end

    // Pixel datapath: rectangle test, scaled product and clear selection.
    always_comb begin
        product     = in_dst_reg * in_src_reg;
        scaled_sum  = (2*ALPHA_W+1)'(product) + (2*ALPHA_W+1)'(product >> 7);
        pix_x       = signed'(CLIP_W'(in_col_reg));
        pix_y       = signed'(CLIP_W'(in_row_reg));
        pix_in_rect = rect.hit_ok &&
                      (pix_x >= rect.x_lo) && (pix_x < rect.x_hi) &&
                      (pix_y >= rect.y_lo) && (pix_y < rect.y_hi);
        if (!rect.active) begin
            alpha_result = in_dst_reg;
        end else if (pix_in_rect) begin
            alpha_result = scaled_sum[2*ALPHA_W-1:ALPHA_W];
        end else if (!cfg_reg.clear_value[CLEAR_W-1]) begin
            alpha_result = cfg_reg.clear_value[ALPHA_W-1:0];
        end else begin
            alpha_result = in_dst_reg;
        end
    end

    // Result register.
    always_comb begin
        if (advance) begin
            out_valid_next = in_valid_reg;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_valid_reg) begin
            out_alpha_reg  <= alpha_result;
            out_inside_reg <= pix_in_rect;
            out_last_reg   <= in_last_reg;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_alpha_out  = out_alpha_reg;
    assign m_inside_res = out_inside_reg;
    assign m_frame_end  = out_last_reg;

    // No pixel is taken while the clip pipeline is still settling.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (settle_cnt_reg != '0) |-> !s_ready)
        else $error("pixel accepted while clip pipeline settles");

    // A register write blocks the input on the following cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_wr_en |=> !s_ready)
        else $error("input not held off after register write");

    // The row only moves when the column wraps.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && !col_wrap) |=> $stable(row_reg))
        else $error("row advanced without column wrap");

    // A pixel in the input register is never dropped while stalled.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !advance) |=> in_valid_reg)
        else $error("stalled pixel lost from input register");

endmodule

`default_nettype wire
